// ===== sv/mono_framebuffer_pixel_plot_core_assert.svh =====
// Assertion helpers shared by the frame store modules.
`ifndef MONO_FRAMEBUFFER_PIXEL_PLOT_CORE_ASSERT_SVH
`define MONO_FRAMEBUFFER_PIXEL_PLOT_CORE_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define MFB_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("frame store assertion failed");

// pre holds -> post holds in the next cycle
`define MFB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("frame store assertion failed");

// cond never holds
`define MFB_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("frame store assertion failed");

`endif

// ===== sv/mfb_pkg.sv =====
`default_nettype none

package mfb_pkg;

    localparam int REQ_W   = 2;
    localparam int POS_W   = 10;
    localparam int COORD_W = 9;
    localparam int IDX_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int ROT_W   = 2;

    localparam logic [REQ_W-1:0] REQ_PLOT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FILL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    localparam logic REG_ROTATION = 1'b0;

    localparam logic [BYTE_W-1:0] BYTE_WHITE = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_BLACK = 8'h00;
    localparam logic [BYTE_W-1:0] MASK_MSB   = 8'h80;

    typedef struct packed {
        logic load_item;
        logic map_en;
        logic addr_en;
        logic walk_en;
        logic walk_init;
        logic result_en;
    } cmd_t;

    typedef struct packed {
        logic is_fill;
        logic walk_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/mfb_ram.sv =====
`default_nettype none

module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1280
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/mfb_ctrl.sv =====
`default_nettype none
`include "mono_framebuffer_pixel_plot_core_assert.svh"

module mfb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire mfb_pkg::status_t status,
    output mfb_pkg::cmd_t        cmd
);

    import mfb_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MAP    = 3'd2;
    localparam logic [2:0] S_ADDR   = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                // clearing pass: whole store to white
                cmd.walk_en   = 1'b1;
                cmd.walk_init = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map_en = 1'b1;
                state_next = status.is_fill ? S_FILL : S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = S_RD;
            end
            S_RD:
            begin
                state_next = S_RESULT;
            end
            S_FILL:
            begin
                cmd.walk_en = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result_en = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `MFB_ASSERT_IMP(a_result_slot_free, clk, rst_n, cmd.result_en, status.out_free)
    `MFB_ASSERT_NEVER(a_walk_exclusive, clk, rst_n, cmd.walk_en && (cmd.result_en || cmd.load_item))
    `MFB_ASSERT_NEXT(a_fill_to_result, clk, rst_n, (state_reg == S_FILL) && status.walk_last, state_reg == S_RESULT)

endmodule

`default_nettype wire

// ===== sv/mfb_datapath.sv =====
`default_nettype none
`include "mono_framebuffer_pixel_plot_core_assert.svh"

module mfb_datapath #(
    parameter int PANEL_WIDTH  = 80,
    parameter int PANEL_HEIGHT = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mfb_pkg::cmd_t                 cmd,
    output mfb_pkg::status_t                   status,
    input  wire logic [mfb_pkg::ROT_W-1:0]     rotation,
    input  wire logic [mfb_pkg::REQ_W-1:0]     req_type,
    input  wire logic signed [mfb_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [mfb_pkg::POS_W-1:0] pos_y,
    input  wire logic                          is_black,
    input  wire logic [mfb_pkg::IDX_W-1:0]     read_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mfb_pkg::IDX_W-1:0]     byte_index,
    output logic      [mfb_pkg::BYTE_W-1:0]    byte_value,
    output logic                               clipped
);

    import mfb_pkg::*;

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam logic [POS_W-1:0]  PW      = POS_W'(PANEL_WIDTH);
    localparam logic [POS_W-1:0]  PH      = POS_W'(PANEL_HEIGHT);
    localparam logic [POS_W-1:0]  PW_M1   = POS_W'(PANEL_WIDTH - 1);
    localparam logic [POS_W-1:0]  PH_M1   = POS_W'(PANEL_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] LAST_AD = ADDR_W'(STORE_BYTES - 1);

    // accepted item
    logic [REQ_W-1:0]  req_reg;
    logic [POS_W-1:0]  x_reg;
    logic [POS_W-1:0]  y_reg;
    logic              black_reg;
    logic [IDX_W-1:0]  rd_reg;

    // mapped coordinate
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic [COORD_W-1:0] px_next;
    logic [COORD_W-1:0] py_next;
    logic               clip_reg;
    logic               clip_next;
    logic [POS_W-1:0]   cw;
    logic [POS_W-1:0]   ch;

    // byte address and bit mask
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [BYTE_W-1:0] mask_reg;
    logic              rd_ok_reg;

    // fill walk
    logic [ADDR_W-1:0] walk_cnt_reg;
    logic [ADDR_W-1:0] walk_cnt_next;
    logic              walk_last;
    logic [BYTE_W-1:0] walk_val;
    logic [BYTE_W-1:0] fill_val;

    // memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] new_byte;
    logic              plot_we;

    // result register
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [BYTE_W-1:0] out_val_reg;
    logic              out_clip_reg;
    logic [IDX_W-1:0]  res_idx;
    logic [BYTE_W-1:0] res_val;
    logic              res_clip;
    logic              out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            req_reg   <= req_type;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            black_reg <= is_black;
            rd_reg    <= read_index;
        end
    end

    // clip against the rotated canvas and map to panel coordinates
    always_comb
    begin
        cw = rotation[0] ? PH : PW;
        ch = rotation[0] ? PW : PH;
        clip_next = x_reg[POS_W-1] || y_reg[POS_W-1] ||
                    ({1'b0, x_reg[COORD_W-1:0]} >= cw) ||
                    ({1'b0, y_reg[COORD_W-1:0]} >= ch);
        case (rotation)
            ROT_90:
            begin
                px_next = COORD_W'(PW_M1 - {1'b0, y_reg[COORD_W-1:0]});
                py_next = x_reg[COORD_W-1:0];
            end
            ROT_180:
            begin
                px_next = COORD_W'(PW_M1 - {1'b0, x_reg[COORD_W-1:0]});
                py_next = COORD_W'(PH_M1 - {1'b0, y_reg[COORD_W-1:0]});
            end
            ROT_270:
            begin
                px_next = y_reg[COORD_W-1:0];
                py_next = COORD_W'(PH_M1 - {1'b0, x_reg[COORD_W-1:0]});
            end
            default:
            begin
                px_next = x_reg[COORD_W-1:0];
                py_next = y_reg[COORD_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            clip_reg <= clip_next;
        end
    end

    always_comb
    begin
        if (req_reg == REQ_READ)
        begin
            idx_next = ADDR_W'(rd_reg);
        end
        else
        begin
            idx_next = ADDR_W'(32'(py_reg) * ROW_BYTES + 32'(px_reg[COORD_W-1:3]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr_en)
        begin
            idx_reg   <= idx_next;
            mask_reg  <= MASK_MSB >> px_reg[2:0];
            rd_ok_reg <= (32'(rd_reg) < STORE_BYTES);
        end
    end

    assign walk_last     = (walk_cnt_reg == LAST_AD);
    assign walk_cnt_next = walk_last ? '0 : walk_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cnt_reg <= '0;
        end
        else if (cmd.walk_en)
        begin
            walk_cnt_reg <= walk_cnt_next;
        end
    end

    assign fill_val = black_reg ? BYTE_BLACK : BYTE_WHITE;
    assign walk_val = cmd.walk_init ? BYTE_WHITE : fill_val;
    assign new_byte = black_reg ? (ram_rdata & ~mask_reg) : (ram_rdata | mask_reg);
    assign plot_we  = cmd.result_en && (req_reg == REQ_PLOT) && !clip_reg;

    assign ram_we    = cmd.walk_en || plot_we;
    assign ram_waddr = cmd.walk_en ? walk_cnt_reg : idx_reg;
    assign ram_wdata = cmd.walk_en ? walk_val : new_byte;

    mfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        res_idx  = '0;
        res_val  = '0;
        res_clip = 1'b0;
        case (req_reg)
            REQ_PLOT:
            begin
                if (clip_reg)
                begin
                    res_clip = 1'b1;
                end
                else
                begin
                    res_idx = IDX_W'(idx_reg);
                    res_val = new_byte;
                end
            end
            REQ_FILL:
            begin
                res_val = fill_val;
            end
            REQ_READ:
            begin
                res_idx = rd_reg;
                res_val = rd_ok_reg ? ram_rdata : BYTE_BLACK;
            end
            default:
            begin
                res_idx = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_en)
        begin
            out_idx_reg  <= res_idx;
            out_val_reg  <= res_val;
            out_clip_reg <= res_clip;
        end
    end

    assign status.is_fill   = (req_reg == REQ_FILL);
    assign status.walk_last = walk_last;
    assign status.out_free  = out_free;

    assign out_valid  = out_valid_reg;
    assign byte_index = out_idx_reg;
    assign byte_value = out_val_reg;
    assign clipped    = out_clip_reg;

    `MFB_ASSERT_NEXT(a_walk_wraps, clk, rst_n, cmd.walk_en && walk_last, walk_cnt_reg == '0)

endmodule

`default_nettype wire

// ===== sv/mono_framebuffer_pixel_plot_core.sv =====
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   req_type pos_x pos_y is_black read_index
// out      out  out_valid / out_stall byte_index byte_value clipped
// cfg      in   APB, pready tied high rotation at byte address 0
//
// Plot, read and unused requests run through the map, address, RAM read and
// read-modify-write steps in that order, on the single write port.
// Fill: one walk over every byte of the store, one byte per cycle.
// After rst_n (async, active low) a clearing pass writes every byte
// white, with in_stall high throughout.
// The result register holds under out_stall; the next item is accepted
// meanwhile and waits at its last step until the register frees.
`default_nettype none

module mono_framebuffer_pixel_plot_core #(
    parameter int PANEL_WIDTH  = 80,
    parameter int PANEL_HEIGHT = 128
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mfb_pkg::REQ_W-1:0]        req_type,
    input  wire logic signed [mfb_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [mfb_pkg::POS_W-1:0] pos_y,
    input  wire logic                             is_black,
    input  wire logic [mfb_pkg::IDX_W-1:0]        read_index,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [mfb_pkg::IDX_W-1:0]        byte_index,
    output logic      [mfb_pkg::BYTE_W-1:0]       byte_value,
    output logic                                  clipped
);

    import mfb_pkg::*;

    logic [ROT_W-1:0] rotation_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
        end
        else if (cfg_wr && (paddr[2] == REG_ROTATION))
        begin
            rotation_reg <= pwdata[ROT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROTATION) ? 32'(rotation_reg) : '0;

    mfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mfb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .rotation   (rotation_reg),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .is_black   (is_black),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .clipped    (clipped)
    );

endmodule

`default_nettype wire
